@@ rtl/core/byte_histogram_code_pattern_counter_macros.svh @@
// Assertion helpers for the byte histogram and pattern counter.
`ifndef BYTE_HISTOGRAM_CODE_PATTERN_COUNTER_MACROS_SVH
`define BYTE_HISTOGRAM_CODE_PATTERN_COUNTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BHCP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BHCP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bhcp_pkg.sv @@
package bhcp_pkg;

    localparam int TAIL_BYTES_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int HIST_BINS_DEF   = 256;
    localparam int NUM_PATTERNS    = 37;
    localparam int PAT_SPAN        = 32;
    localparam int N_W             = 7;
    localparam int SKIP_W          = 5;
    localparam int LEN_W           = 6;
    localparam int PID_W           = 6;

    typedef enum logic [1:0] {
        OP_DATA   = 2'd0,
        OP_FINISH = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_PAT   = 2'd0,
        KIND_TOTAL = 2'd1,
        KIND_BIN   = 2'd2,
        KIND_ERR   = 2'd3
    } t_kind;

    typedef logic [PAT_SPAN-1:0][7:0] t_span;

    typedef struct packed {
        logic clr;
        logic scan;
        logic snap;
        logic step;
    } t_lane_ctl;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic is_addsub(input logic [7:0] v);
        return v == 8'h83 || v == 8'h81 || v == 8'h2c;
    endfunction

    function automatic logic is_evl_tail(input logic [7:0] v);
        return v == 8'h01 || v == 8'hc1 || v == 8'hc8 || v == 8'hc9 ||
               v == 8'hc0 || v == 8'hd0 || v == 8'hd1 || v == 8'hda;
    endfunction

    // farthest return word wins
    function automatic logic [LEN_W-1:0] ret_search(input t_span d, input logic [N_W-1:0] n,
                                                    input logic [2:0] reps,
                                                    input logic [7:0] a, input logic [7:0] b,
                                                    input logic [7:0] c, input logic [7:0] e);
        logic [LEN_W-1:0] len;
        len = '0;
        for (int r = 0; r <= 6; r++) begin
            if (3'(r) <= reps && N_W'(8 + 4 * r) <= n && d[4+4*r] == a &&
                d[5+4*r] == b && d[6+4*r] == c && d[7+4*r] == e) begin
                len = LEN_W'(8 + 4 * r);
            end
        end
        return len;
    endfunction

    function automatic logic [LEN_W-1:0] pat_len(input logic [PID_W-1:0] p, input t_span d,
                                                 input logic [N_W-1:0] n);
        logic [LEN_W-1:0] m;
        m = '0;
        case (p)
            6'd0: if (n >= 2 && d[0] == 8'hc9 && d[1] == 8'hc3) m = 6'd2;
            6'd1: if (n >= 3 && d[1] >= 8'h50 && d[1] <= 8'h5f && d[2] == 8'hc3) m = 6'd3;
            6'd2: begin
                if (n >= 5 && d[0] == 8'h48 && is_addsub(d[1]) && d[2] == 8'hc4) begin
                    if (d[4] == 8'hc3) m = 6'd5;
                    else if (n >= 8 && d[7] == 8'hc3) m = 6'd8;
                end
            end
            6'd3: if (n >= 4 && d[0] == 8'h55 && d[1] == 8'h48 && d[2] == 8'h89 &&
                      d[3] == 8'he5) m = 6'd4;
            6'd4: if (n >= 4 && d[0] == 8'h48 && is_addsub(d[1]) && d[2] == 8'hec) m = 6'd4;
            6'd5: if (n >= 8 && d[0] == 8'he8 && d[1] == 8'hbd && d[4] == 8'he1 &&
                      d[5] == 8'h2f && d[6] == 8'hff && d[7] == 8'h1e) m = 6'd8;
            6'd6: if (n >= 8 && d[0] == 8'he4 && d[1] == 8'h9d && d[2] == 8'he0 &&
                      d[3] == 8'h04 && d[4] == 8'he1 && d[5] == 8'h2f && d[6] == 8'hff &&
                      d[7] == 8'h1e) m = 6'd8;
            6'd7: if (n >= 4 && d[0] == 8'he9 && d[1] == 8'h2d) m = 6'd4;
            6'd8: if (n >= 4 && d[0] == 8'he5 && d[1] == 8'h2d && d[2] == 8'he0 &&
                      d[3] == 8'h04) m = 6'd4;
            6'd9: if (n >= 8 && d[2] == 8'hbd && d[3] == 8'he8 && d[4] == 8'h1e &&
                      d[5] == 8'hff && d[6] == 8'h2f && d[7] == 8'he1) m = 6'd8;
            6'd10: if (n >= 8 && d[0] == 8'h04 && d[1] == 8'he0 && d[2] == 8'h9d &&
                       d[3] == 8'he4 && d[4] == 8'h1e && d[5] == 8'hff && d[6] == 8'h2f &&
                       d[7] == 8'he1) m = 6'd8;
            6'd11: if (n >= 4 && d[2] == 8'h2d && d[3] == 8'he9) m = 6'd4;
            6'd12: if (n >= 4 && d[0] == 8'h04 && d[1] == 8'he0 && d[2] == 8'h2d &&
                       d[3] == 8'he5) m = 6'd4;
            6'd13: if (n >= 2 && d[0] == 8'h00 && d[1] == 8'h01) m = 6'd2;
            6'd14: if (n >= 2 && d[0] == 8'hff && d[1] == 8'hfe) m = 6'd2;
            6'd15: if (n >= 2 && d[0] == 8'h01 && d[1] == 8'h00) m = 6'd2;
            6'd16: if (n >= 2 && d[0] == 8'hfe && d[1] == 8'hff) m = 6'd2;
            6'd17: if (n >= 8 && d[0] == 8'h8f && d[1] == 8'hbf)
                       m = ret_search(d, n, 3'd4, 8'h03, 8'he0, 8'h00, 8'h08);
            6'd18: if (n >= 4 && d[0] == 8'h27 && d[1] == 8'hbd && d[2] == 8'hff) m = 6'd4;
            6'd19: if (n >= 8 && d[0] == 8'h3c && d[1] == 8'h1c && d[4] == 8'h9c &&
                       d[5] == 8'h27) m = 6'd8;
            6'd20: if (n >= 8 && d[2] == 8'hbf && d[3] == 8'h8f)
                       m = ret_search(d, n, 3'd4, 8'h08, 8'h00, 8'he0, 8'h03);
            6'd21: if (n >= 4 && d[1] == 8'hff && d[2] == 8'hbd && d[3] == 8'h27) m = 6'd4;
            6'd22: if (n >= 8 && d[2] == 8'h1c && d[3] == 8'h3c && d[6] == 8'h9c &&
                       d[7] == 8'h27) m = 6'd8;
            6'd23: if (n >= 4 && d[0] >= 8'h10 && d[0] <= 8'h13 && is_evl_tail(d[3]))
                       m = 6'd4;
            6'd24: if (n >= 4 && d[0] >= 8'h7d && d[0] <= 8'h7f &&
                       (d[3] == 8'h1e || d[3] == 8'h5e || d[3] == 8'h9e)) m = 6'd4;
            6'd25, 6'd27: if (n >= 8 && d[2] == 8'h03 && d[3] == 8'ha6)
                       m = ret_search(d, n, 3'd6, 8'h4e, 8'h80, 8'h00, 8'h20);
            6'd26, 6'd28: if (n >= 8 && d[0] == 8'h94 && d[1] == 8'h21 && d[4] == 8'h7c &&
                              d[5] == 8'h08 && d[6] == 8'h02 && d[7] == 8'ha6) m = 6'd8;
            6'd29: if (n >= 4 && d[0] == 8'h7c && d[1] == 8'h08 && d[2] == 8'h02 &&
                       d[3] == 8'ha6) m = 6'd4;
            6'd30: if (n >= 4 && d[0] == 8'hf8 && d[1] == 8'h61) m = 6'd4;
            6'd31, 6'd33: if (n >= 8 && d[0] == 8'ha6 && d[1] == 8'h03)
                       m = ret_search(d, n, 3'd6, 8'h20, 8'h00, 8'h80, 8'h4e);
            6'd32, 6'd34: if (n >= 8 && d[2] == 8'h21 && d[3] == 8'h94 && d[4] == 8'ha6 &&
                              d[5] == 8'h02 && d[6] == 8'h08 && d[7] == 8'h7c) m = 6'd8;
            6'd35: if (n >= 2 && d[0] == 8'h07 && d[1] == 8'hf4) m = 6'd2;
            6'd36: if (n >= 6 && d[0] == 8'heb && d[2] >= 8'hf0 && d[5] == 8'h24) m = 6'd6;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/bhcp_hist_mem.sv @@
module bhcp_hist_mem
    import bhcp_pkg::*;
#(
    parameter int HIST_BINS   = HIST_BINS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clr,
    input  logic                         i_rd_en,
    input  logic [$clog2(HIST_BINS)-1:0] i_rd_addr,
    output logic [COUNT_WIDTH-1:0]       o_rd_data,
    input  logic                         i_wr_en,
    input  logic [$clog2(HIST_BINS)-1:0] i_wr_addr,
    input  logic [COUNT_WIDTH-1:0]       i_wr_data
);

    logic [COUNT_WIDTH-1:0] r_mem [HIST_BINS];
    logic [HIST_BINS-1:0]   r_vld;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // never-written bins read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

@@ rtl/core/bhcp_pat_lane.sv @@
module bhcp_pat_lane
    import bhcp_pkg::*;
#(
    parameter int PAT_ID      = 0,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_lane_ctl              i_ctl,
    input  t_span                  i_span,
    input  logic [N_W-1:0]         i_n,
    output logic [COUNT_WIDTH-1:0] o_sh_cnt
);

    logic [SKIP_W-1:0]      r_skip;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [SKIP_W-1:0]      r_sh_skip;
    logic [COUNT_WIDTH-1:0] r_sh_cnt;
    logic [LEN_W-1:0]       w_len;

    assign w_len = pat_len(PID_W'(PAT_ID), i_span, i_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_skip <= '0;
            r_cnt  <= '0;
        end else if (i_ctl.scan) begin
            if (r_skip != '0) begin
                r_skip <= r_skip - 1'b1;
            end else if (w_len != '0) begin
                r_skip <= SKIP_W'(w_len - 1'b1);
                if (r_cnt != '1) r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // working copy for the tail pass
    always_ff @(posedge i_clk) begin
        if (i_ctl.snap) begin
            r_sh_skip <= r_skip;
            r_sh_cnt  <= r_cnt;
        end else if (i_ctl.step) begin
            if (r_sh_skip != '0) begin
                r_sh_skip <= r_sh_skip - 1'b1;
            end else if (w_len != '0) begin
                r_sh_skip <= SKIP_W'(w_len - 1'b1);
                if (r_sh_cnt != '1) r_sh_cnt <= r_sh_cnt + 1'b1;
            end
        end
    end

    assign o_sh_cnt = r_sh_cnt;

endmodule

@@ rtl/core/byte_histogram_code_pattern_counter.sv @@
// Byte histogram and code pattern counter. Each input word carries an opcode in tuser:
// a data byte reads its histogram bin at accept, then does a saturating write-back, and
// advances a 37-lane pattern scan over a 32-byte look-ahead window; a bin read reads
// at accept and returns its count once the output register is free; clear needs no
// clearing pass, since per-bin valid bits drop at once. Finish snapshots the window,
// then steps through each pending tail position (the bytes held in the window, one less
// once it is full), then emits 37 pattern counts and the total, or a single error
// word on an empty stream. Finish leaves the stored state untouched. One word is in
// work at a time; the input is ready only while the sequencer is idle.
module byte_histogram_code_pattern_counter
    import bhcp_pkg::*;
#(
    parameter int TAIL_BYTES  = TAIL_BYTES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int HIST_BINS   = HIST_BINS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [15:8] bin_index
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] item_index, [39:8] count_value
    output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
    output logic        m_axis_tlast    // last_result
);

    `include "byte_histogram_code_pattern_counter_macros.svh"

    localparam int FILL_W = $clog2(TAIL_BYTES + 1);
    localparam int WIN_AW = $clog2(TAIL_BYTES);
    localparam int ADDR_W = $clog2(HIST_BINS);
    localparam int EMIT_W = $clog2(NUM_PATTERNS + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DATA  = 5'b00010,
        S_RDBIN = 5'b00100,
        S_TAIL  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [FILL_W-1:0]      r_fill;
    logic [FILL_W-1:0]      r_tail_n;
    logic [COUNT_WIDTH-1:0] r_total;
    logic [EMIT_W-1:0]      r_emit_idx;
    logic                   r_err;
    logic [7:0]             r_byte;
    logic [7:0]             r_bin;
    logic [7:0]             r_win [TAIL_BYTES];
    logic [7:0]             r_sh  [TAIL_BYTES];

    logic                   r_out_valid;
    logic [1:0]             r_out_kind;
    logic [7:0]             r_out_idx;
    logic [31:0]            r_out_val;
    logic                   r_out_last;

    logic                   w_acc;
    t_op                    w_op;
    logic [7:0]             w_data_byte;
    logic [7:0]             w_bin_index;
    logic                   w_full;
    logic                   w_start;
    logic                   w_slot;
    logic                   w_load;
    logic [1:0]             w_kind;
    logic [7:0]             w_idx;
    logic [31:0]            w_val;
    logic                   w_last;
    logic [COUNT_WIDTH-1:0] w_sel_cnt;
    logic [COUNT_WIDTH-1:0] w_rd_data;
    logic [COUNT_WIDTH-1:0] w_wr_data;
    logic                   w_rd_en;
    logic [ADDR_W-1:0]      w_rd_addr;
    logic                   w_clr;
    t_lane_ctl              w_ctl;
    t_span                  w_span;
    logic [N_W-1:0]         w_n;
    logic [COUNT_WIDTH-1:0] w_lane_cnt [NUM_PATTERNS];

    // unpack the input word
    assign w_op        = t_op'(s_axis_tuser);
    assign w_data_byte = s_axis_tdata[7:0];
    assign w_bin_index = s_axis_tdata[15:8];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_fill == FILL_W'(TAIL_BYTES));
    assign w_start       = w_full;
    assign w_clr         = w_acc && (w_op == OP_CLEAR);

    // histogram read at accept, write-back in the S_DATA state that follows
    assign w_rd_en   = w_acc && (w_op == OP_DATA || w_op == OP_READ);
    assign w_rd_addr = (w_op == OP_DATA) ? ADDR_W'(w_data_byte) : ADDR_W'(w_bin_index);
    assign w_wr_data = (w_rd_data != '1) ? w_rd_data + 1'b1 : w_rd_data;

    bhcp_hist_mem #(
        .HIST_BINS   (HIST_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (w_clr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (r_state == S_DATA),
        .i_wr_addr (ADDR_W'(r_byte)),
        .i_wr_data (w_wr_data)
    );

    // pattern lanes see the live window while streaming, the tail copy while finishing
    always_comb begin
        for (int j = 0; j < PAT_SPAN; j++) begin
            w_span[j] = (r_state == S_TAIL) ? r_sh[j] : r_win[j];
        end
        w_n = (r_state == S_TAIL) ? N_W'(r_tail_n) : N_W'(TAIL_BYTES);
        w_ctl.clr  = w_clr;
        w_ctl.scan = (r_state == S_DATA) && w_full;
        w_ctl.snap = w_acc && (w_op == OP_FINISH);
        w_ctl.step = (r_state == S_TAIL);
    end

    for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_lane
        bhcp_pat_lane #(
            .PAT_ID      (g),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_span   (w_span),
            .i_n      (w_n),
            .o_sh_cnt (w_lane_cnt[g])
        );
    end

    always_comb begin
        w_sel_cnt = '0;
        for (int i = 0; i < NUM_PATTERNS; i++) begin
            if (r_emit_idx == EMIT_W'(i)) w_sel_cnt = w_lane_cnt[i];
        end
    end

    // result selection; load only when the output register is free
    assign w_slot = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        w_kind  = KIND_PAT;
        w_idx   = '0;
        w_val   = '0;
        w_last  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (w_op)
                        OP_DATA:   n_state = S_DATA;
                        OP_FINISH: n_state = (r_fill == '0) ? S_EMIT : S_TAIL;
                        OP_READ:   n_state = S_RDBIN;
                        OP_CLEAR:  n_state = S_IDLE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_DATA: n_state = S_IDLE;
            S_RDBIN: begin
                if (w_slot) begin
                    w_load  = 1'b1;
                    w_kind  = KIND_BIN;
                    w_idx   = r_bin;
                    w_val   = sat32(64'(w_rd_data));
                    w_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_TAIL: begin
                if (r_tail_n == FILL_W'(1)) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot) begin
                    w_load = 1'b1;
                    priority if (r_err) begin
                        w_kind  = KIND_ERR;
                        w_last  = 1'b1;
                        n_state = S_IDLE;
                    end else if (r_emit_idx < EMIT_W'(NUM_PATTERNS)) begin
                        w_kind = KIND_PAT;
                        w_idx  = 8'(r_emit_idx);
                        w_val  = sat32(64'(w_sel_cnt));
                    end else begin
                        w_kind  = KIND_TOTAL;
                        w_val   = sat32(64'(r_total));
                        w_last  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_total     <= '0;
            r_tail_n    <= '0;
            r_emit_idx  <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_clr) begin
                r_fill  <= '0;
                r_total <= '0;
            end else if (w_acc && w_op == OP_DATA) begin
                if (r_total != '1) r_total <= r_total + 1'b1;
                if (!w_full) r_fill <= r_fill + 1'b1;
            end
            if (w_acc && w_op == OP_FINISH) begin
                r_err      <= (r_fill == '0);
                r_emit_idx <= '0;
                r_tail_n   <= r_fill - FILL_W'(w_start);
            end else if (r_state == S_TAIL) begin
                r_tail_n <= r_tail_n - 1'b1;
            end else if (r_state == S_EMIT && w_load) begin
                r_emit_idx <= r_emit_idx + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // window, tail copy and output payload
    always_ff @(posedge i_clk) begin
        if (w_acc && w_op == OP_DATA) begin
            r_byte <= w_data_byte;
            if (w_full) begin
                for (int i = 0; i < TAIL_BYTES - 1; i++) r_win[i] <= r_win[i+1];
                r_win[TAIL_BYTES-1] <= w_data_byte;
            end else begin
                r_win[r_fill[WIN_AW-1:0]] <= w_data_byte;
            end
        end
        if (w_acc && w_op == OP_READ) begin
            r_bin <= w_bin_index;
        end
        // drop the already decided first position when the window is full
        if (w_acc && w_op == OP_FINISH) begin
            for (int i = 0; i < TAIL_BYTES; i++) begin
                if (w_start) r_sh[i] <= (i < TAIL_BYTES - 1) ? r_win[(i+1)%TAIL_BYTES] : 8'h00;
                else         r_sh[i] <= r_win[i];
            end
        end else if (r_state == S_TAIL) begin
            for (int i = 0; i < TAIL_BYTES; i++) begin
                r_sh[i] <= (i < TAIL_BYTES - 1) ? r_sh[(i+1)%TAIL_BYTES] : 8'h00;
            end
        end
        if (w_load) begin
            r_out_kind <= w_kind;
            r_out_idx  <= w_idx;
            r_out_val  <= w_val;
            r_out_last <= w_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_val, r_out_idx};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    `BHCP_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= FILL_W'(TAIL_BYTES), "window fill overrun")
    `BHCP_ASSERT_IMP(a_tail_live, r_state == S_TAIL, r_tail_n != '0, "tail pass with no position")
    `BHCP_ASSERT_IMP(a_emit_bound, r_state == S_EMIT, r_emit_idx <= EMIT_W'(NUM_PATTERNS), "emit index past total")
    `BHCP_ASSERT_IMP(a_pat_not_last, m_axis_tvalid && m_axis_tuser == KIND_PAT, !m_axis_tlast, "pattern word flagged last")
    `BHCP_ASSERT_NXT(a_data_wb, w_acc && w_op == OP_DATA, r_state == S_DATA, "histogram write-back skipped")

endmodule
